// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i while rst_ni is high.
`define ZADD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition seen at one edge is followed by another at the next edge.
`define ZADD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/zadd_pkg.sv
// Types, codes and delta tables of the zapped audio delta decoder.
package zadd_pkg;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_TWO  = 2'd1,
    PH_FOUR = 2'd2,
    PH_LIT  = 2'd3
  } phase_e;

  // Mode field of a code byte (top two bits).
  localparam logic [1:0] ModeTwo     = 2'b00;
  localparam logic [1:0] ModeFour    = 2'b01;
  localparam logic [1:0] ModeRaw     = 2'b10;
  localparam logic [1:0] ModeSilence = 2'b11;

  localparam int unsigned LimitW   = 20;
  localparam int unsigned CountW   = 21;
  localparam int unsigned LeftW    = 22;
  localparam int unsigned ResCntW  = 6;
  localparam int unsigned BurstLen = 4;

  localparam logic [CountW-1:0]  CountMax   = {CountW{1'b1}};
  localparam logic [LimitW-1:0]  LimitReset = 20'd65535;
  localparam logic [7:0]         PredReset  = 8'h80;
  localparam logic [ResCntW-1:0] MaxRes     = 6'd32;

  localparam logic signed [4:0] Delta2 [4] = '{-5'sd2, -5'sd1, 5'sd0, 5'sd1};
  localparam logic signed [4:0] Delta4 [16] = '{
    -5'sd9, -5'sd8, -5'sd6, -5'sd5, -5'sd4, -5'sd3, -5'sd2, -5'sd1,
    5'sd0, 5'sd1, 5'sd2, 5'sd3, 5'sd4, 5'sd5, 5'sd6, 5'sd8
  };

  // Add a small signed delta to a sample, clamp to 0..255.
  function automatic logic [7:0] sat_add(logic [7:0] p, logic signed [4:0] d);
    logic [9:0] sum;
    sum = {2'b00, p} + {{5{d[4]}}, d};
    if (sum[9]) begin
      return 8'd0;
    end else if (sum[8]) begin
      return 8'hFF;
    end
    return sum[7:0];
  endfunction

endpackage

// File: rtl/zapped_audio_delta_decoder_unit.sv
// Top level of the zapped audio delta decoder.
//
// Decodes a byte stream of zapped audio into unsigned 8-bit samples. Each accepted input word
// is decoded in the cycle it is taken: the predictor, phase, run and limit counters are
// updated at once, and the samples that the byte yields land in a four-entry burst register.
// The burst register feeds the output register one word per cycle while out_ready_i does not
// stall it. A byte gives four results for a two-bit data byte, two for a four-bit data byte,
// one for a literal, a raw delta or a done report, data+1 (at most 32) for a silence code,
// and none for a code that opens a run. A new input word is taken in the cycle the last word
// of the current burst moves to the output register. Results pass through the burst register
// and then the output register. A done report (sample_valid 0, done_res 1, last 1) answers
// every byte after the sample limit was reached at a code byte, and every byte after reset
// until a start word. sample_limit is loaded at a start word; writes are taken at any time.
module zapped_audio_delta_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [zadd_pkg::LimitW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  code_byte_i,
  input  logic                        start_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  sample_o,
  output logic                        sample_valid_o,
  output logic                        last_o,
  output logic                        done_res_o,
  output logic [zadd_pkg::CountW-1:0] consumed_count_o
);
  import zadd_pkg::*;

  // Configuration and decoder state.
  logic [LimitW-1:0]        limit_q;
  logic [7:0]               pred_q, pred_d;
  phase_e                   phase_q, phase_d;
  logic [5:0]               run_left_q, run_left_d;
  logic signed [LeftW-1:0]  left_q, left_d;
  logic [CountW-1:0]        count_q, count_d;
  logic                     fin_q, fin_d;

  // Burst register: results of one input word still to be emitted.
  logic                     busy_q, busy_d;
  logic [ResCntW-1:0]       cnt_q, cnt_d;
  logic [7:0]               vals_q [BurstLen];
  logic [7:0]               vals_d [BurstLen];
  logic                     rep_q, rep_d;
  logic                     done_q, done_d;
  logic [CountW-1:0]        bcount_q, bcount_d;

  // Output register.
  logic                     out_valid_q;
  logic [7:0]               sample_q;
  logic                     svalid_q, last_q, dres_q;
  logic [CountW-1:0]        ocount_q;

  logic in_accept, move;

  // Decode signals.
  logic [7:0]              pred0;
  logic signed [LeftW-1:0] left0;
  logic [CountW-1:0]       count0;
  phase_e                  phase0;
  logic [5:0]              run_left0;
  logic                    fin1;
  logic [7:0]              v2 [BurstLen];
  logic [7:0]              v4 [2];
  logic [7:0]              raw_val;
  logic [5:0]              data;
  logic [ResCntW-1:0]      n_res;
  logic [7:0]              res_vals [BurstLen];
  logic                    res_rep;

  // Hand over the burst to the output register when that one is free or drains now.
  assign move       = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || (move && (cnt_q == ResCntW'(1)));
  assign in_accept  = in_valid_i && in_ready_o;

  // A start word rewinds the stream before the byte is decoded.
  assign pred0     = start_req_i ? PredReset : pred_q;
  assign left0     = start_req_i ? LeftW'(signed'({1'b0, limit_q})) : left_q;
  assign count0    = start_req_i ? '0 : count_q;
  assign phase0    = start_req_i ? PH_CODE : phase_q;
  assign run_left0 = start_req_i ? 6'd0 : run_left_q;
  assign fin1      = (start_req_i ? 1'b0 : fin_q)
                   || ((phase0 == PH_CODE) && (left0[LeftW-1] || (left0 == '0)));
  assign data      = code_byte_i[5:0];

  // Chain the per-pair and per-nibble saturating adds.
  assign v2[0]   = sat_add(pred0, Delta2[code_byte_i[1:0]]);
  assign v2[1]   = sat_add(v2[0], Delta2[code_byte_i[3:2]]);
  assign v2[2]   = sat_add(v2[1], Delta2[code_byte_i[5:4]]);
  assign v2[3]   = sat_add(v2[2], Delta2[code_byte_i[7:6]]);
  assign v4[0]   = sat_add(pred0, Delta4[code_byte_i[3:0]]);
  assign v4[1]   = sat_add(v4[0], Delta4[code_byte_i[7:4]]);
  // Raw delta wraps modulo 256.
  assign raw_val = pred0 + {{3{code_byte_i[4]}}, code_byte_i[4:0]};

  always_comb begin
    pred_d     = pred0;
    left_d     = left0;
    count_d    = count0;
    phase_d    = phase0;
    run_left_d = run_left0;
    fin_d      = fin1;
    n_res      = '0;
    res_rep    = 1'b0;
    for (int k = 0; k < BurstLen; k++) begin
      res_vals[k] = pred0;
    end
    if (fin1) begin
      // Done report: byte not consumed.
      n_res       = ResCntW'(1);
      res_vals[0] = 8'd0;
    end else begin
      count_d = (count0 == CountMax) ? count0 : count0 + CountW'(1);
      if (phase0 == PH_CODE) begin
        unique case (code_byte_i[7:6])
          ModeRaw: begin
            if (code_byte_i[5]) begin
              pred_d      = raw_val;
              res_vals[0] = raw_val;
              n_res       = ResCntW'(1);
            end else begin
              phase_d    = PH_LIT;
              run_left_d = data;
            end
          end
          ModeFour: begin
            phase_d    = PH_FOUR;
            run_left_d = data;
          end
          ModeTwo: begin
            phase_d    = PH_TWO;
            run_left_d = data;
          end
          ModeSilence: begin
            // Clip long silence to the burst limit.
            n_res   = (data >= 6'd31) ? MaxRes : ResCntW'(data) + ResCntW'(1);
            res_rep = 1'b1;
          end
          default: begin
            n_res = '0;
          end
        endcase
      end else begin
        priority if (phase0 == PH_LIT) begin
          pred_d      = code_byte_i;
          res_vals[0] = code_byte_i;
          n_res       = ResCntW'(1);
        end else if (phase0 == PH_FOUR) begin
          pred_d      = v4[1];
          res_vals[0] = v4[0];
          res_vals[1] = v4[1];
          n_res       = ResCntW'(2);
        end else begin
          pred_d = v2[3];
          for (int k = 0; k < BurstLen; k++) begin
            res_vals[k] = v2[k];
          end
          n_res = ResCntW'(BurstLen);
        end
        if (run_left0 == 6'd0) begin
          phase_d = PH_CODE;
        end else begin
          run_left_d = run_left0 - 6'd1;
        end
      end
      left_d = left0 - LeftW'(n_res);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q     <= PredReset;
      phase_q    <= PH_CODE;
      run_left_q <= 6'd0;
      left_q     <= '0;
      count_q    <= '0;
      fin_q      <= 1'b1;
    end else if (in_accept) begin
      pred_q     <= pred_d;
      phase_q    <= phase_d;
      run_left_q <= run_left_d;
      left_q     <= left_d;
      count_q    <= count_d;
      fin_q      <= fin_d;
    end
  end

  // Burst register: load on a word that gives results, else shift out one per move.
  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    vals_d   = vals_q;
    rep_d    = rep_q;
    done_d   = done_q;
    bcount_d = bcount_q;
    if (move) begin
      if (cnt_q == ResCntW'(1)) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - ResCntW'(1);
        if (!rep_q) begin
          for (int k = 0; k < BurstLen - 1; k++) begin
            vals_d[k] = vals_q[k+1];
          end
        end
      end
    end
    if (in_accept && (n_res != '0)) begin
      busy_d   = 1'b1;
      cnt_d    = n_res;
      vals_d   = res_vals;
      rep_d    = res_rep;
      done_d   = fin1;
      bcount_d = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vals_q   <= vals_d;
    rep_q    <= rep_d;
    done_q   <= done_d;
    bcount_q <= bcount_d;
  end

  // Output register: take the head of the burst, drop the word once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      sample_q <= vals_q[0];
      svalid_q <= !done_q;
      last_q   <= (cnt_q == ResCntW'(1));
      dres_q   <= done_q;
      ocount_q <= bcount_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_o         = sample_q;
  assign sample_valid_o   = svalid_q;
  assign last_o           = last_q;
  assign done_res_o       = dres_q;
  assign consumed_count_o = ocount_q;

endmodule

// File: rtl/zadd_checker.sv
// Port-level checker for the zapped audio delta decoder, bound to the top level.
`include "assert_macros.svh"

module zadd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [7:0]                  sample_o,
  input logic                        sample_valid_o,
  input logic                        last_o,
  input logic                        done_res_o,
  input logic [zadd_pkg::CountW-1:0] consumed_count_o
);

  // Hold a stalled result word.
  `ZADD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(sample_o) && $stable(sample_valid_o) && $stable(last_o) && $stable(done_res_o) && $stable(consumed_count_o), "result word changed while stalled")

  // A done report is a lone zero word.
  `ZADD_ASSERT(a_done_form, out_valid_o && done_res_o |-> !sample_valid_o && last_o && (sample_o == 8'd0), "malformed done report")

  // Words of one burst follow without a gap.
  `ZADD_ASSERT_NEXT(a_burst_gapless, out_valid_o && out_ready_i && !last_o, out_valid_o, "gap inside a burst")

  // Words of one burst carry one byte count.
  `ZADD_ASSERT_NEXT(a_burst_count, out_valid_o && out_ready_i && !last_o, consumed_count_o == $past(consumed_count_o), "byte count changed inside a burst")

endmodule

bind zapped_audio_delta_decoder_unit zadd_checker u_zadd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .sample_o         (sample_o),
  .sample_valid_o   (sample_valid_o),
  .last_o           (last_o),
  .done_res_o       (done_res_o),
  .consumed_count_o (consumed_count_o)
);
